// ===== hw/rtl/abps_pkg.sv =====
package abps_pkg;

    localparam int CFG_W = 16;
    localparam int TIME_W = 32;
    localparam int LEVEL_W = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SET_LEVEL = 3'd1,
        KIND_ACK       = 3'd2,
        KIND_PLAY      = 3'd3,
        KIND_STOP      = 3'd4,
        KIND_RESET     = 3'd5,
        KIND_AUDIO     = 3'd6,
        KIND_NONE      = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SHORT  = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_LONG   = 2'd2,
        CFG_GAP    = 2'd3
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] SHORT_RST  = 16'd100;
    localparam logic [CFG_W-1:0] MEDIUM_RST = 16'd200;
    localparam logic [CFG_W-1:0] LONG_RST   = 16'd500;
    localparam logic [CFG_W-1:0] GAP_RST    = 16'd100;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_INFO     = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_WARNING  = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_DANGER   = 3'd4;

    localparam logic [TIME_W-1:0] REPEAT_INFO     = 32'd5000;
    localparam logic [TIME_W-1:0] REPEAT_WARNING  = 32'd3000;
    localparam logic [TIME_W-1:0] REPEAT_CRITICAL = 32'd2000;
    localparam logic [TIME_W-1:0] REPEAT_DANGER   = 32'd1000;

    localparam logic [COUNT_W-1:0] BEEPS_INFO     = 4'd1;
    localparam logic [COUNT_W-1:0] BEEPS_WARNING  = 4'd2;
    localparam logic [COUNT_W-1:0] BEEPS_CRITICAL = 4'd3;
    localparam logic [COUNT_W-1:0] BEEPS_DANGER   = 4'd5;
    localparam logic [COUNT_W-1:0] BEEPS_SAT      = 4'd15;

    typedef struct packed {
        logic [CFG_W-1:0] short_beep_ticks;
        logic [CFG_W-1:0] medium_beep_ticks;
        logic [CFG_W-1:0] long_beep_ticks;
        logic [CFG_W-1:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEVEL_W-1:0] new_level;
        logic [COUNT_W-1:0] beep_number;
        logic [CFG_W-1:0]   beep_ticks;
        logic               audio_on;
    } in_item_t;

    typedef struct packed {
        logic               buzzer;
        logic [LEVEL_W-1:0] level_now;
        logic               acked;
    } out_item_t;

endpackage

// ===== hw/rtl/abps_if.sv =====
interface abps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  new_level;
    logic [3:0]  beep_number;
    logic [15:0] beep_ticks;
    logic        audio_on;

    modport source (output valid, kind, new_level, beep_number, beep_ticks, audio_on,
                    input ready);
    modport sink (input valid, kind, new_level, beep_number, beep_ticks, audio_on,
                  output ready);
endinterface

interface abps_out_if;
    logic       valid;
    logic       ready;
    logic       buzzer;
    logic [2:0] level_now;
    logic       acked;

    modport source (output valid, buzzer, level_now, acked, input ready);
    modport sink (input valid, buzzer, level_now, acked, output ready);
endinterface

// ===== hw/rtl/alert_beep_pattern_sequencer_unit.sv =====
// Beats pass the input register, then the result register. Throughput: one beat per
// cycle unless the output stalls; the state update is a single compare-and-update step.
// While a result beat waits on the output, the input register takes at most one more beat.
// Reset (rst_n low, async): pipeline empty, time and counters zero, level none,
// sound enabled, beep and gap lengths at their default values.
module alert_beep_pattern_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    abps_in_if.sink     in_ch,
    abps_out_if.source  out_ch
);
    import abps_pkg::*;

    cfg_t      cfg;
    in_item_t  s1_item_reg;
    logic      s1_valid_reg;
    out_item_t res;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      step_en;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign step_en     = s1_valid_reg && advance;

    abps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abps_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_item_reg.kind        <= kind_t'(in_ch.kind);
            s1_item_reg.new_level   <= in_ch.new_level;
            s1_item_reg.beep_number <= in_ch.beep_number;
            s1_item_reg.beep_ticks  <= in_ch.beep_ticks;
            s1_item_reg.audio_on    <= in_ch.audio_on;
        end
        if (step_en)
            out_item_reg <= res;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.buzzer    = out_item_reg.buzzer;
    assign out_ch.level_now = out_item_reg.level_now;
    assign out_ch.acked     = out_item_reg.acked;
endmodule

// ===== hw/rtl/abps_cfg_regs.sv =====
module abps_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output abps_pkg::cfg_t      cfg
);
    import abps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_beep_ticks  <= SHORT_RST;
            cfg_reg.medium_beep_ticks <= MEDIUM_RST;
            cfg_reg.long_beep_ticks   <= LONG_RST;
            cfg_reg.gap_ticks         <= GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SHORT:  cfg_reg.short_beep_ticks  <= cfg_data;
                CFG_MEDIUM: cfg_reg.medium_beep_ticks <= cfg_data;
                CFG_LONG:   cfg_reg.long_beep_ticks   <= cfg_data;
                CFG_GAP:    cfg_reg.gap_ticks         <= cfg_data;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hw/rtl/abps_seq.sv =====
module abps_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  abps_pkg::in_item_t   item,
    input  abps_pkg::cfg_t       cfg,
    output abps_pkg::out_item_t  res
);
    import abps_pkg::*;

    logic [TIME_W-1:0]  tick_time_reg, tick_time_next;
    logic [TIME_W-1:0]  mark_time_reg, mark_time_next;
    logic [COUNT_W-1:0] beeps_done_reg, beeps_done_next;
    logic [COUNT_W-1:0] beeps_target_reg, beeps_target_next;
    logic               tone_reg, tone_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               ack_reg, ack_next;
    logic               sound_reg, sound_next;

    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] lvl_target;
    logic [CFG_W-1:0]   lvl_len;
    logic [TIME_W-1:0]  lvl_repeat;

    always_comb
    begin
        unique case (level_reg)
            LEVEL_INFO:
            begin
                lvl_target = BEEPS_INFO;
                lvl_len    = cfg.short_beep_ticks;
                lvl_repeat = REPEAT_INFO;
            end
            LEVEL_WARNING:
            begin
                lvl_target = BEEPS_WARNING;
                lvl_len    = cfg.medium_beep_ticks;
                lvl_repeat = REPEAT_WARNING;
            end
            LEVEL_CRITICAL:
            begin
                lvl_target = BEEPS_CRITICAL;
                lvl_len    = cfg.medium_beep_ticks;
                lvl_repeat = REPEAT_CRITICAL;
            end
            default:
            begin
                lvl_target = BEEPS_DANGER;
                lvl_len    = cfg.long_beep_ticks;
                lvl_repeat = REPEAT_DANGER;
            end
        endcase
    end

    assign now     = tick_time_reg + 32'd1;
    assign elapsed = now - mark_time_reg;

    always_comb
    begin
        tick_time_next    = tick_time_reg;
        mark_time_next    = mark_time_reg;
        beeps_done_next   = beeps_done_reg;
        beeps_target_next = beeps_target_reg;
        tone_next         = tone_reg;
        level_next        = level_reg;
        ack_next          = ack_reg;
        sound_next        = sound_reg;
        if (step_en)
        begin
            unique case (item.kind)
                KIND_TICK:
                begin
                    tick_time_next = now;
                    if (sound_reg)
                    begin
                        if (level_reg == LEVEL_NONE || ack_reg)
                        begin
                            if (tone_reg)
                            begin
                                tone_next         = 1'b0;
                                beeps_target_next = '0;
                            end
                        end
                        else if (beeps_target_reg == '0)
                        begin
                            if (elapsed >= lvl_repeat)
                            begin
                                beeps_target_next = lvl_target;
                                beeps_done_next   = '0;
                            end
                        end
                        else if (tone_reg)
                        begin
                            if (elapsed >= {16'd0, lvl_len})
                            begin
                                tone_next      = 1'b0;
                                mark_time_next = now;
                                if (beeps_done_reg != BEEPS_SAT)
                                    beeps_done_next = beeps_done_reg + 4'd1;
                            end
                        end
                        else if (elapsed >= {16'd0, cfg.gap_ticks})
                        begin
                            if (beeps_done_reg < beeps_target_reg)
                                tone_next = 1'b1;
                            else
                                beeps_target_next = '0;
                            mark_time_next = now;
                        end
                    end
                end
                KIND_SET_LEVEL:
                begin
                    level_next = (item.new_level > LEVEL_DANGER) ? LEVEL_DANGER
                                                                 : item.new_level;
                    ack_next   = 1'b0;
                end
                KIND_ACK:
                begin
                    ack_next          = 1'b1;
                    tone_next         = 1'b0;
                    beeps_target_next = '0;
                end
                KIND_PLAY:
                begin
                    beeps_target_next = item.beep_number;
                    beeps_done_next   = '0;
                    mark_time_next    = tick_time_reg;
                    if (item.beep_number != '0 && sound_reg)
                        tone_next = 1'b1;
                end
                KIND_STOP:
                begin
                    tone_next         = 1'b0;
                    beeps_target_next = '0;
                end
                KIND_RESET:
                begin
                    level_next        = LEVEL_NONE;
                    ack_next          = 1'b0;
                    tone_next         = 1'b0;
                    beeps_target_next = '0;
                end
                KIND_AUDIO:
                begin
                    sound_next = item.audio_on;
                    if (!item.audio_on)
                    begin
                        tone_next         = 1'b0;
                        beeps_target_next = '0;
                    end
                end
                default:
                begin
                    tone_next = tone_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg    <= '0;
            mark_time_reg    <= '0;
            beeps_done_reg   <= '0;
            beeps_target_reg <= '0;
            tone_reg         <= 1'b0;
            level_reg        <= LEVEL_NONE;
            ack_reg          <= 1'b0;
            sound_reg        <= 1'b1;
        end
        else
        begin
            tick_time_reg    <= tick_time_next;
            mark_time_reg    <= mark_time_next;
            beeps_done_reg   <= beeps_done_next;
            beeps_target_reg <= beeps_target_next;
            tone_reg         <= tone_next;
            level_reg        <= level_next;
            ack_reg          <= ack_next;
            sound_reg        <= sound_next;
        end
    end

    assign res.buzzer    = tone_next;
    assign res.level_now = level_next;
    assign res.acked     = ack_next;
endmodule

// ===== hw/rtl/abps_checker.sv =====
module abps_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       buzzer,
    input logic [2:0] level_now,
    input logic       acked
);
    import abps_pkg::*;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_now <= LEVEL_DANGER)
        else $error("level above danger");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("accepted beat produced no result");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(buzzer) && $stable(level_now)
                                       && $stable(acked)))
        else $error("result payload changed while stalled");
endmodule

bind alert_beep_pattern_sequencer_unit abps_props u_abps_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .buzzer    (out_ch.buzzer),
    .level_now (out_ch.level_now),
    .acked     (out_ch.acked)
);
